### rtl/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

  localparam int unsigned ChW     = 5;
  localparam int unsigned ColorW  = 3 * ChW;
  localparam int unsigned PhaseW  = 9;
  localparam int unsigned WeightW = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  localparam logic [PhaseW-1:0]  WeightOne = 9'h080;
  localparam logic [PhaseW:0]    PhaseWrap = 10'h100;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_BLEND = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ColorW-1:0] color_a;
    logic [ColorW-1:0] color_b;
    logic [PhaseW-1:0] phase;
  } rpb_item_t;

  function automatic logic [PhaseW-1:0] next_phase(logic [PhaseW-1:0] phase,
                                                   logic [PhaseW-1:0] step);
    logic [PhaseW:0] sum;
    sum = {1'b0, phase} + {1'b0, step};
    return (sum > PhaseWrap) ? '0 : sum[PhaseW-1:0];
  endfunction

  function automatic logic [WeightW-1:0] phase_weight(logic [PhaseW-1:0] phase);
    logic [PhaseW-1:0] diff;
    diff = PhaseWrap[PhaseW-1:0] - phase;
    if (phase < WeightOne) return phase[WeightW-1:0];
    return diff[WeightW-1:0];
  endfunction

endpackage

### rtl/rpb_front.sv
`timescale 1ns / 1ps

module rpb_front import rpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [PhaseW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_e              in_cmd_i,
  input  logic [ColorW-1:0] in_color_a_i,
  input  logic [ColorW-1:0] in_color_b_i,
  input  logic              item_ready_i,
  output logic              item_valid_o,
  output rpb_item_t         item_o,
  output logic [PhaseW-1:0] phase_o
);

  logic [PhaseW-1:0] step_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              valid_q;
  rpb_item_t         item_q;
  logic              accept;

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign phase_d    = (in_cmd_i == CMD_TICK) ? next_phase(phase_q, step_q) : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        valid_q <= 1'b1;
      end else if (item_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd     <= in_cmd_i;
      item_q.color_a <= in_color_a_i;
      item_q.color_b <= in_color_b_i;
      item_q.phase   <= phase_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign phase_o      = phase_q;

endmodule

### rtl/rpb_blend.sv
`timescale 1ns / 1ps

module rpb_blend import rpb_pkg::*; (
  input  rpb_item_t          item_i,
  output logic [ColorW-1:0]  color_o,
  output logic [WeightW-1:0] weight_o
);

  logic [WeightW-1:0] w;
  logic [WeightW-1:0] w_inv;
  logic [ColorW-1:0]  mix;

  assign w     = phase_weight(item_i.phase);
  assign w_inv = WeightOne[WeightW-1:0] - w;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [ChW-1:0]         a, b;
    logic [ChW+WeightW-1:0] sum;
    assign a   = item_i.color_a[c*ChW +: ChW];
    assign b   = item_i.color_b[c*ChW +: ChW];
    assign sum = ({{WeightW{1'b0}}, a} * {{ChW{1'b0}}, w_inv})
               + ({{WeightW{1'b0}}, b} * {{ChW{1'b0}}, w});
    assign mix[c*ChW +: ChW] = sum[7 +: ChW];
  end

  assign color_o  = (item_i.cmd == CMD_TICK) ? '0 : mix;
  assign weight_o = w;

endmodule

### rtl/rgb555_pulsing_palette_blend.sv
`timescale 1ns / 1ps

// Pulsing RGB555 blend.
// Input stream: tuser = cmd (0 tick, 1 blend), tdata = color_a, color_b.
// A tick advances the pulse phase by the configured step and returns color 0
// with the new weight; a blend word mixes A and B per 5-bit channel with the
// current weight w (0..128) and returns the color and w.
// Output stream: tdata = blended_color, blend_weight.
// Config channel: one 9-bit step register, always ready; write it only while
// the block is idle.
// From input accept to output valid a word passes an input register holding
// the word and its phase, then the three channel multiplies into the output
// register. One word per cycle is sustained while the receiver is ready.
// Reset clears the phase, the step and both valid flags.
// When the receiver stalls, the output register holds, the input register
// fills, and then s_axis_tready drops until the output drains.

module rgb555_pulsing_palette_blend import rpb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PhaseW-1:0]   cfg_data_i,      // phase_step
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,    // color_a[14:0], color_b[29:15], zero pad
  input  logic                s_axis_tuser,    // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata     // blended_color[14:0], blend_weight[22:15], pad
);

  logic               item_valid;
  logic               item_ready;
  rpb_item_t          item;
  logic [PhaseW-1:0]  phase;
  logic [ColorW-1:0]  mix_color;
  logic [WeightW-1:0] mix_weight;
  logic               out_valid_q;
  logic [ColorW-1:0]  out_color_q;
  logic [WeightW-1:0] out_weight_q;
  cmd_e               in_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_cmd      = cmd_e'(s_axis_tuser);

  rpb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (in_cmd),
    .in_color_a_i (s_axis_tdata[ColorW-1:0]),
    .in_color_b_i (s_axis_tdata[2*ColorW-1:ColorW]),
    .item_ready_i (item_ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .phase_o      (phase)
  );

  rpb_blend u_blend (
    .item_i   (item),
    .color_o  (mix_color),
    .weight_o (mix_weight)
  );

  assign item_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready) begin
      out_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready && item_valid) begin
      out_color_q  <= mix_color;
      out_weight_q <= mix_weight;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-ColorW-WeightW){1'b0}}, out_weight_q, out_color_q};

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase <= PhaseWrap[PhaseW-1:0])
    else $error("pulse phase above wrap");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_weight_q <= WeightOne[WeightW-1:0])
    else $error("blend weight above one");

  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("staged word lost under stall");

  a_tick_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && item_ready && item.cmd == CMD_TICK |=> out_color_q == '0)
    else $error("tick word produced a color");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rpb_pkg::*;

  localparam int unsigned FullWeight = 128;
  localparam int unsigned PhaseTop   = 256;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned PhaseItems = 100;

  typedef struct {
    logic [ColorW-1:0]  color;
    logic [WeightW-1:0] weight;
  } pixel_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [PhaseW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // color_a[14:0], color_b[29:15], pad
  logic                s_axis_tuser  = 1'b0; // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // blended_color[14:0], blend_weight[22:15], pad

  // model state
  logic [PhaseW-1:0] step_reg  = '0;
  logic [PhaseW-1:0] phase_reg = '0;
  pixel_t            blend_results_q[$];

  int  mismatches   = 0;
  bit  calm         = 1'b0;
  int  stall_reqs   = 0;
  int  stall_served = 0;
  int  hold_left    = 0;

  rgb555_pulsing_palette_blend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [WeightW-1:0] weight_of(input logic [PhaseW-1:0] ph);
    logic [PhaseW-1:0] down;
    down = PhaseW'(PhaseTop) - ph;
    if (ph < PhaseW'(FullWeight)) return ph[WeightW-1:0];
    return down[WeightW-1:0];
  endfunction

  function automatic logic [ColorW-1:0] mix555(input logic [ColorW-1:0] a,
                                               input logic [ColorW-1:0] b,
                                               input logic [WeightW-1:0] w);
    logic [ColorW-1:0] res;
    int unsigned ca, cb, m;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca = a[ch*ChW +: ChW];
      cb = b[ch*ChW +: ChW];
      m  = (ca * (FullWeight - w) + cb * w) >> 7;
      res[ch*ChW +: ChW] = m[ChW-1:0];
    end
    return res;
  endfunction

  task automatic predict_word(input cmd_e c, input logic [ColorW-1:0] a,
                              input logic [ColorW-1:0] b);
    logic [PhaseW:0] sum;
    pixel_t px;
    if (c == CMD_TICK) begin
      sum = {1'b0, phase_reg} + {1'b0, step_reg};
      phase_reg = (sum > (PhaseW+1)'(PhaseTop)) ? '0 : sum[PhaseW-1:0];
      px.color  = '0;
      px.weight = weight_of(phase_reg);
    end else begin
      px.weight = weight_of(phase_reg);
      px.color  = mix555(a, b, px.weight);
    end
    blend_results_q.push_back(px);
  endtask

  // checker
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blend_results_q.size() == 0) begin
        $error("unexpected word: blended_color %h blend_weight %0d",
               m_axis_tdata[ColorW-1:0], m_axis_tdata[ColorW +: WeightW]);
        mismatches++;
      end else begin
        px = blend_results_q.pop_front();
        if (m_axis_tdata[ColorW-1:0] !== px.color) begin
          $error("blended_color: expected %h, got %h", px.color, m_axis_tdata[ColorW-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[ColorW +: WeightW] !== px.weight) begin
          $error("blend_weight: expected %0d, got %0d", px.weight,
                 m_axis_tdata[ColorW +: WeightW]);
          mismatches++;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (stall_reqs != stall_served) begin
      hold_left = LongHold;
      stall_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  task automatic wait_drained();
    while (blend_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(input cmd_e c, input logic [ColorW-1:0] a,
                           input logic [ColorW-1:0] b);
    while (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {2'b00, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(c, a, b);
  endtask

  task automatic write_step(input logic [PhaseW-1:0] v);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    step_reg = v;
  endtask

  function automatic logic [ColorW-1:0] pick_color();
    logic [ColorW-1:0] c;
    case ($urandom_range(7))
      0: c = '0;
      1: c = '1;
      2: begin
        c = '0;
        for (int ch = 0; ch < 3; ch++)
          c[ch*ChW +: ChW] = $urandom_range(1) ? 5'h1f : 5'h00;
      end
      default: c = ColorW'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_word(($urandom_range(99) < 40) ? CMD_TICK : CMD_BLEND, pick_color(), pick_color());
  endtask

  task automatic test_extremes();
    send_word(CMD_BLEND, 15'h0000, 15'h7fff);
    send_word(CMD_BLEND, 15'h7fff, 15'h0000);
    send_word(CMD_TICK,  15'h7fff, 15'h7fff);
    write_step(9'd128);
    send_word(CMD_TICK,  15'h0000, 15'h0000);
    send_word(CMD_BLEND, 15'h0000, 15'h7fff);
    send_word(CMD_BLEND, 15'h7fff, 15'h0000);
    send_word(CMD_BLEND, 15'h7fff, 15'h7fff);
    send_word(CMD_TICK,  15'h0000, 15'h0000);
    send_word(CMD_BLEND, 15'h7c1f, 15'h03e0);
  endtask

  task automatic test_phase_wrap();
    send_word(CMD_TICK, 15'h0000, 15'h0000);  // 256 + 128 overflows to zero
    write_step(9'd511);
    send_word(CMD_TICK, 15'h1234, 15'h4321);
    write_step(9'd256);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    send_word(CMD_BLEND, 15'h7fff, 15'h0000);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    write_step(9'd257);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    write_step(9'd64);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    send_word(CMD_BLEND, 15'h5294, 15'h2d6b);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
    send_word(CMD_BLEND, 15'h5294, 15'h2d6b);
    write_step(9'd1);
    send_word(CMD_TICK, 15'h0000, 15'h0000);
  endtask

  task automatic test_random_steps();
    logic [PhaseW-1:0] steps[8];
    steps = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511, 9'd0, 9'd0};
    steps[6] = PhaseW'($urandom_range(PhaseTop));
    steps[7] = PhaseW'($urandom);
    foreach (steps[k]) begin
      write_step(steps[k]);
      send_random(PhaseItems);
    end
  endtask

  task automatic test_no_idle();
    write_step(PhaseW'($urandom_range(PhaseTop)));
    calm = 1'b1;
    send_random(PhaseItems);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    write_step(PhaseW'($urandom_range(1, 40)));
    stall_reqs++;
    send_random(60);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    send_random(20);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_phase_wrap();
    test_random_steps();
    test_no_idle();
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (blend_results_q.size() != 0) begin
      $error("%0d expected words never arrived", blend_results_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
